FILE: rtl/matrix_multiply_engine_core_assert.svh
// Assertion macros used by the port-level checker module of the matrix multiply engine.
// Depends on nothing; included by the checker file.
`ifndef MATRIX_MULTIPLY_ENGINE_CORE_ASSERT_SVH
`define MATRIX_MULTIPLY_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MME_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/mme_pkg.sv
// Shared opcodes, register indexes and field widths of the matrix multiply engine.
// Depends on nothing.
package mme_pkg;

	localparam int ELEM_W = 16;
	localparam int PROD_W = 32;
	localparam int ACC_W  = 40;
	localparam int IDX_W  = 3;
	localparam int SIZE_W = 4;

	localparam logic [1:0] OP_WRITE_A = 2'd0;
	localparam logic [1:0] OP_WRITE_B = 2'd1;
	localparam logic [1:0] OP_COMPUTE = 2'd2;

	localparam logic [1:0] REG_ROWS  = 2'd0;
	localparam logic [1:0] REG_INNER = 2'd1;
	localparam logic [1:0] REG_COLS  = 2'd2;

endpackage

FILE: rtl/matrix_multiply_engine_core.sv
// Matrix multiply engine: stores A and B, then one shared multiply-accumulate unit walks C.
// Element writes leave busy low, and a new transaction is taken next cycle.
// A compute holds busy while the multiply-accumulate walk runs and until its pipeline drains;
// the walk is serialised by the single multiplier and the one read port of each store.
// Each element of C is strobed out once its sum over the inner dimension is complete.
// Reset clears the sequencer and sets the sizes to 3, 4 and 2; the stores are not cleared.
module matrix_multiply_engine_core
	import mme_pkg::*;
#(
	parameter int MAX_ROWS  = 8,
	parameter int MAX_INNER = 8,
	parameter int MAX_COLS  = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               opcode,
	input  logic [IDX_W-1:0]         row_index,
	input  logic [IDX_W-1:0]         col_index,
	input  logic signed [ELEM_W-1:0] element_value,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [1:0]               cfg_index,
	input  logic [SIZE_W-1:0]        cfg_data,
	output logic                     strobe,
	output logic [IDX_W-1:0]         out_row,
	output logic [IDX_W-1:0]         out_col,
	output logic signed [ACC_W-1:0]  product_value,
	output logic                     last_result
);

	localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int KW     = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
	localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int A_DEP  = MAX_ROWS * MAX_INNER;
	localparam int B_DEP  = MAX_INNER * MAX_COLS;
	localparam int A_AW   = (A_DEP > 1) ? $clog2(A_DEP) : 1;
	localparam int B_AW   = (B_DEP > 1) ? $clog2(B_DEP) : 1;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic              state_q;
	logic [SIZE_W-1:0] rows_q, inner_q, cols_q;
	logic [RW-1:0]     i_q, i_last_q;
	logic [KW-1:0]     k_q, k_last_q;
	logic [CW-1:0]     j_q, j_last_q;

	logic              accept, do_compute, we_a, we_b;
	logic [A_AW-1:0]   a_waddr, a_raddr;
	logic [B_AW-1:0]   b_waddr, b_raddr;
	logic [ELEM_W-1:0] a_rdata, b_rdata;
	logic              k_end, j_end, i_end;

	logic              valid_s1, first_s1, kend_s1, last_s1;
	logic [RW-1:0]     i_s1;
	logic [CW-1:0]     j_s1;
	logic              valid_s2, first_s2, kend_s2, last_s2;
	logic [RW-1:0]     i_s2;
	logic [CW-1:0]     j_s2;
	logic signed [PROD_W-1:0] prod_s2;

	logic signed [ACC_W-1:0] acc_q;
	logic              strobe_q, last_q;
	logic [IDX_W-1:0]  row_q, col_q;

	function automatic logic [RW-1:0] last_row(input logic [SIZE_W-1:0] v);
		if (v == '0) begin
			return '0;
		end else if (32'(v) > MAX_ROWS) begin
			return RW'(MAX_ROWS - 1);
		end
		return RW'(32'(v) - 1);
	endfunction

	function automatic logic [KW-1:0] last_inner(input logic [SIZE_W-1:0] v);
		if (v == '0) begin
			return '0;
		end else if (32'(v) > MAX_INNER) begin
			return KW'(MAX_INNER - 1);
		end
		return KW'(32'(v) - 1);
	endfunction

	function automatic logic [CW-1:0] last_col(input logic [SIZE_W-1:0] v);
		if (v == '0) begin
			return '0;
		end else if (32'(v) > MAX_COLS) begin
			return CW'(MAX_COLS - 1);
		end
		return CW'(32'(v) - 1);
	endfunction

	assign cfg_ready  = 1'b1;
	assign busy       = state_q | valid_s1 | valid_s2 | strobe_q;
	assign accept     = start & ~busy;
	assign do_compute = accept && (opcode == OP_COMPUTE);
	assign we_a = accept && (opcode == OP_WRITE_A)
		&& (32'(row_index) < MAX_ROWS) && (32'(col_index) < MAX_INNER);
	assign we_b = accept && (opcode == OP_WRITE_B)
		&& (32'(row_index) < MAX_INNER) && (32'(col_index) < MAX_COLS);

	assign a_waddr = A_AW'(32'(row_index) * MAX_INNER + 32'(col_index));
	assign b_waddr = B_AW'(32'(row_index) * MAX_COLS + 32'(col_index));
	assign a_raddr = A_AW'(32'(i_q) * MAX_INNER + 32'(k_q));
	assign b_raddr = B_AW'(32'(k_q) * MAX_COLS + 32'(j_q));

	assign k_end = (k_q == k_last_q);
	assign j_end = (j_q == j_last_q);
	assign i_end = (i_q == i_last_q);

	mme_ram #(.WIDTH(ELEM_W), .DEPTH(A_DEP)) u_store_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (a_waddr),
		.wdata (element_value),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	mme_ram #(.WIDTH(ELEM_W), .DEPTH(B_DEP)) u_store_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (b_waddr),
		.wdata (element_value),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= SIZE_W'(3);
			inner_q <= SIZE_W'(4);
			cols_q  <= SIZE_W'(2);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ROWS:  rows_q  <= cfg_data;
				REG_INNER: inner_q <= cfg_data;
				REG_COLS:  cols_q  <= cfg_data;
				default:   ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			i_last_q <= '0;
			j_last_q <= '0;
			k_last_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (do_compute) begin
						state_q  <= ST_RUN;
						i_q      <= '0;
						j_q      <= '0;
						k_q      <= '0;
						i_last_q <= last_row(rows_q);
						j_last_q <= last_col(cols_q);
						k_last_q <= last_inner(inner_q);
					end
				end
				ST_RUN: begin
					if (!k_end) begin
						k_q <= k_q + 1'b1;
					end else begin
						k_q <= '0;
						if (!j_end) begin
							j_q <= j_q + 1'b1;
						end else begin
							j_q <= '0;
							if (i_end) begin
								state_q <= ST_IDLE;
							end else begin
								i_q <= i_q + 1'b1;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_RUN);
			valid_s2 <= valid_s1;
			strobe_q <= valid_s2 & kend_s2;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (k_q == '0);
		kend_s1  <= k_end;
		last_s1  <= k_end & j_end & i_end;
		i_s1     <= i_q;
		j_s1     <= j_q;
		first_s2 <= first_s1;
		kend_s2  <= kend_s1;
		last_s2  <= last_s1;
		i_s2     <= i_s1;
		j_s2     <= j_s1;
		prod_s2  <= $signed(a_rdata) * $signed(b_rdata);
		if (valid_s2) begin
			if (first_s2) begin
				acc_q <= ACC_W'(prod_s2);
			end else begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
		row_q  <= IDX_W'(i_s2);
		col_q  <= IDX_W'(j_s2);
		last_q <= last_s2;
	end

	assign strobe        = strobe_q;
	assign out_row       = row_q;
	assign out_col       = col_q;
	assign product_value = acc_q;
	assign last_result   = last_q;

endmodule

FILE: rtl/mme_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module mme_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/mme_checker.sv
// Port-level checker for the matrix multiply engine, bound to the top level.
// Depends on mme_pkg and the assertion macros in matrix_multiply_engine_core_assert.svh.
`include "matrix_multiply_engine_core_assert.svh"

module mme_checker
	import mme_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] opcode,
	input logic       strobe,
	input logic       last_result
);

	`MME_ASSERT_IMPLY(a_strobe_busy, clk, arst_n, strobe, busy)
	`MME_ASSERT_NEXT(a_compute_busy, clk, arst_n, start && !busy && opcode == OP_COMPUTE, busy)
	`MME_ASSERT_NEXT(a_last_ends, clk, arst_n, strobe && last_result, !strobe)
	`MME_ASSERT_IMPLY(a_busy_cause, clk, arst_n, $rose(busy),
		$past(start) && $past(opcode) == OP_COMPUTE)

endmodule

bind matrix_multiply_engine_core mme_checker u_mme_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.opcode      (opcode),
	.strobe      (strobe),
	.last_result (last_result)
);

FILE: sim/matrix_multiply_engine_core_checker.sv
// Checker for the matrix multiply engine: watches the load, compute, size and result channels.
// Keeps its own copy of both stores and the size registers and predicts every element of C.
// Depends on mme_pkg for field widths, opcodes and register indexes.
module matrix_multiply_engine_core_checker
	import mme_pkg::*;
#(
	parameter int MAX_ROWS  = 8,
	parameter int MAX_INNER = 8,
	parameter int MAX_COLS  = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic [1:0]               opcode,
	input  logic [IDX_W-1:0]         row_index,
	input  logic [IDX_W-1:0]         col_index,
	input  logic signed [ELEM_W-1:0] element_value,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [1:0]               cfg_index,
	input  logic [SIZE_W-1:0]        cfg_data,
	input  logic                     strobe,
	input  logic [IDX_W-1:0]         out_row,
	input  logic [IDX_W-1:0]         out_col,
	input  logic signed [ACC_W-1:0]  product_value,
	input  logic                     last_result,
	output int                       mismatches,
	output int                       results_due,
	output int                       results_seen
);

	typedef struct packed {
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [ACC_W-1:0] value;
		logic                    last;
	} c_element_t;

	logic signed [ELEM_W-1:0] a_store [MAX_ROWS*MAX_INNER];
	logic signed [ELEM_W-1:0] b_store [MAX_INNER*MAX_COLS];
	logic [SIZE_W-1:0] rows_setting  = 4'd3;
	logic [SIZE_W-1:0] inner_setting = 4'd4;
	logic [SIZE_W-1:0] cols_setting  = 4'd2;
	c_element_t c_elements_due [$];

	initial begin
		mismatches = 0;
		results_due = 0;
		results_seen = 0;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	function automatic int unsigned size_in_use(input logic [SIZE_W-1:0] setting,
			input int unsigned limit);
		if (setting == 0) begin
			return 1;
		end
		if (setting > limit) begin
			return limit;
		end
		return setting;
	endfunction

	task automatic predict_product_grid();
		int unsigned n_rows;
		int unsigned n_inner;
		int unsigned n_cols;
		logic signed [ACC_W-1:0] sum;
		c_element_t elem;
		n_rows  = size_in_use(rows_setting, MAX_ROWS);
		n_inner = size_in_use(inner_setting, MAX_INNER);
		n_cols  = size_in_use(cols_setting, MAX_COLS);
		for (int i = 0; i < n_rows; i++) begin
			for (int j = 0; j < n_cols; j++) begin
				sum = '0;
				for (int k = 0; k < n_inner; k++) begin
					sum = sum + a_store[i*MAX_INNER + k] * b_store[k*MAX_COLS + j];
				end
				elem.row   = IDX_W'(i);
				elem.col   = IDX_W'(j);
				elem.value = sum;
				elem.last  = (i + 1 == n_rows) && (j + 1 == n_cols);
				c_elements_due.push_back(elem);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		c_element_t want;
		if (!arst_n) begin
			rows_setting  = 4'd3;
			inner_setting = 4'd4;
			cols_setting  = 4'd2;
			c_elements_due.delete();
		end else begin
			if (strobe) begin
				results_seen++;
				if (c_elements_due.size() == 0) begin
					report_mismatch("result with nothing expected", product_value, 0);
				end else begin
					want = c_elements_due.pop_front();
					if (out_row !== want.row) begin
						report_mismatch("out_row", out_row, want.row);
					end
					if (out_col !== want.col) begin
						report_mismatch("out_col", out_col, want.col);
					end
					if (product_value !== want.value) begin
						report_mismatch("product_value", product_value, want.value);
					end
					if (last_result !== want.last) begin
						report_mismatch("last_result", last_result, want.last);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ROWS: begin
						rows_setting = cfg_data;
					end
					REG_INNER: begin
						inner_setting = cfg_data;
					end
					REG_COLS: begin
						cols_setting = cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (start && !busy) begin
				case (opcode)
					OP_WRITE_A: begin
						if (row_index < MAX_ROWS && col_index < MAX_INNER) begin
							a_store[row_index*MAX_INNER + col_index] = element_value;
						end
					end
					OP_WRITE_B: begin
						if (row_index < MAX_INNER && col_index < MAX_COLS) begin
							b_store[row_index*MAX_COLS + col_index] = element_value;
						end
					end
					OP_COMPUTE: begin
						predict_product_grid();
					end
					default: begin
					end
				endcase
			end
		end
		results_due = c_elements_due.size();
	end

endmodule

FILE: sim/tb_matrix_multiply_engine_core.sv
// Testbench top for the matrix multiply engine: clock, reset, load and compute stimulus, verdict.
// Depends on mme_pkg, the engine core and matrix_multiply_engine_core_checker.
module tb_matrix_multiply_engine_core;
	import mme_pkg::*;

	localparam int MAX_ROWS  = 8;
	localparam int MAX_INNER = 8;
	localparam int MAX_COLS  = 8;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int ITEM_TARGET  = 310;
	localparam int DRAIN_CYCLES = 8;
	localparam int IDLE_LIMIT   = 1000;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [1:0]               opcode;
	logic [IDX_W-1:0]         row_index;
	logic [IDX_W-1:0]         col_index;
	logic signed [ELEM_W-1:0] element_value;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [1:0]               cfg_index;
	logic [SIZE_W-1:0]        cfg_data;
	logic                     strobe;
	logic [IDX_W-1:0]         out_row;
	logic [IDX_W-1:0]         out_col;
	logic signed [ACC_W-1:0]  product_value;
	logic                     last_result;

	int mismatches;
	int results_due;
	int results_seen;
	int idle_cycles = 0;
	int load_count = 0;
	int compute_count = 0;
	int size_writes = 0;
	bit no_gaps = 0;
	bit a_written [MAX_ROWS*MAX_INNER];
	bit b_written [MAX_INNER*MAX_COLS];
	int unsigned rows_eff = 3;
	int unsigned inner_eff = 4;
	int unsigned cols_eff = 2;

	matrix_multiply_engine_core #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_INNER(MAX_INNER),
		.MAX_COLS (MAX_COLS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.row_index    (row_index),
		.col_index    (col_index),
		.element_value(element_value),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.strobe       (strobe),
		.out_row      (out_row),
		.out_col      (out_col),
		.product_value(product_value),
		.last_result  (last_result)
	);

	matrix_multiply_engine_core_checker #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_INNER(MAX_INNER),
		.MAX_COLS (MAX_COLS)
	) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.row_index    (row_index),
		.col_index    (col_index),
		.element_value(element_value),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.strobe       (strobe),
		.out_row      (out_row),
		.out_col      (out_col),
		.product_value(product_value),
		.last_result  (last_result),
		.mismatches   (mismatches),
		.results_due  (results_due),
		.results_seen (results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((start && !busy) || (cfg_valid && cfg_ready) || strobe) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Watchdog expired after %0d cycles without a transaction.", idle_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic int unsigned dimension_in_use(input logic [SIZE_W-1:0] setting,
			input int unsigned limit);
		if (setting == 0) begin
			return 1;
		end
		if (setting > limit) begin
			return limit;
		end
		return setting;
	endfunction

	function automatic logic [SIZE_W-1:0] draw_dimension();
		int unsigned pick;
		pick = $urandom_range(0, 15);
		if (pick == 0) begin
			return '0;
		end
		if (pick < 3) begin
			return SIZE_W'($urandom_range(8, 15));
		end
		return SIZE_W'($urandom_range(1, 4));
	endfunction

	// Start stays high across back-to-back transactions; it is lowered before a gap and while draining.
	task automatic send_item(input logic [1:0] op, input logic [IDX_W-1:0] row,
			input logic [IDX_W-1:0] col, input logic [ELEM_W-1:0] value);
		int unsigned gap;
		gap = no_gaps ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		row_index <= row;
		col_index <= col;
		element_value <= value;
		do @(posedge clk); while (busy);
		if (op == OP_WRITE_A) begin
			a_written[row*MAX_INNER + col] = 1'b1;
		end
		if (op == OP_WRITE_B) begin
			b_written[row*MAX_COLS + col] = 1'b1;
		end
		if (op != OP_UNUSED) begin
			load_count++;
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		do @(negedge clk); while (results_due != 0 || busy);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_size(input logic [1:0] index, input logic [SIZE_W-1:0] value);
		if (!no_gaps) begin
			repeat ($urandom_range(0, 9)) @(posedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		size_writes++;
		@(posedge clk);
	endtask

	task automatic set_dimensions(input logic [SIZE_W-1:0] rows, input logic [SIZE_W-1:0] inner,
			input logic [SIZE_W-1:0] cols);
		write_size(REG_ROWS, rows);
		write_size(REG_INNER, inner);
		write_size(REG_COLS, cols);
		rows_eff  = dimension_in_use(rows, MAX_ROWS);
		inner_eff = dimension_in_use(inner, MAX_INNER);
		cols_eff  = dimension_in_use(cols, MAX_COLS);
	endtask

	// Every store entry the product will read that is not yet written is loaded first, with a random value.
	task automatic run_compute();
		int i;
		int j;
		for (i = 0; i < rows_eff; i++) begin
			for (j = 0; j < inner_eff; j++) begin
				if (!a_written[i*MAX_INNER + j]) begin
					send_item(OP_WRITE_A, IDX_W'(i), IDX_W'(j), ELEM_W'($urandom));
				end
			end
		end
		for (i = 0; i < inner_eff; i++) begin
			for (j = 0; j < cols_eff; j++) begin
				if (!b_written[i*MAX_COLS + j]) begin
					send_item(OP_WRITE_B, IDX_W'(i), IDX_W'(j), ELEM_W'($urandom));
				end
			end
		end
		send_item(OP_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom));
		compute_count++;
	endtask

	initial begin : stimulus
		int phase;
		int unsigned n_loads;
		logic [1:0] op;
		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_WRITE_A;
		row_index = '0;
		col_index = '0;
		element_value = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_ROWS;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single element products at the extremes of the Q8.8 range.
		set_dimensions(4'd1, 4'd1, 4'd1);
		send_item(OP_WRITE_A, 3'd0, 3'd0, 16'sh8000);
		send_item(OP_WRITE_B, 3'd0, 3'd0, 16'sh8000);
		run_compute();
		send_item(OP_WRITE_A, 3'd0, 3'd0, 16'sh7fff);
		run_compute();
		send_item(OP_UNUSED, 3'd7, 3'd7, 16'shffff);
		// Loads beyond the sizes in use are kept for later products.
		send_item(OP_WRITE_A, 3'd7, 3'd7, 16'sh7fff);
		send_item(OP_WRITE_B, 3'd7, 3'd7, 16'sh8001);
		wait_drained();

		// Zero sizes act as one and an oversized inner size saturates: largest possible sum.
		set_dimensions(4'd0, 4'd15, 4'd0);
		for (int k = 0; k < MAX_INNER; k++) begin
			send_item(OP_WRITE_A, 3'd0, IDX_W'(k), 16'sh8000);
			send_item(OP_WRITE_B, IDX_W'(k), 3'd0, 16'sh8000);
		end
		run_compute();

		phase = 0;
		while (load_count < ITEM_TARGET) begin
			wait_drained();
			if (phase == 0) begin
				set_dimensions(4'd15, 4'd1, 4'd15);
			end else if ($urandom_range(0, 2) != 0) begin
				set_dimensions(draw_dimension(), draw_dimension(), draw_dimension());
			end
			no_gaps = ($urandom_range(0, 2) == 0);
			n_loads = $urandom_range(0, 12);
			repeat (n_loads) begin
				if ($urandom_range(0, 9) == 0) begin
					op = OP_UNUSED;
				end else begin
					op = $urandom_range(0, 1) ? OP_WRITE_B : OP_WRITE_A;
				end
				send_item(op, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom));
			end
			run_compute();
			if ($urandom_range(0, 3) == 0) begin
				run_compute();
			end
			phase++;
		end
		wait_drained();

		$display("Covered %0d loads and products (%0d products) under %0d size register writes.",
			load_count, compute_count, size_writes);
		$display("Checked %0d result elements of C against the prediction.", results_seen);
		if (mismatches == 0 && results_due == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
